>>> rtl/core/klbl_pkg.sv
// klbl_pkg: shared widths, register indexes, divisor and reciprocal constants and the
// command and status types between the limiter controller and datapath
// no dependencies
package klbl_pkg;

  localparam int unsigned KEY_W      = 8;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned EVENT_W    = 16;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_W      = 12;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PROD_W     = TIME_W + LEVEL_W;
  localparam int unsigned QUO_W      = LEVEL_W + DIV_W;
  localparam int unsigned PP_W       = CHUNK_W + LEVEL_W;
  localparam int unsigned ENTRY_W    = TIME_W + LEVEL_W;
  localparam int unsigned KEY_SPAN   = 1 << KEY_W;
  localparam int unsigned DVD_W      = QUO_W - CHUNK_W;
  localparam int unsigned RCP_W      = DVD_W + 1;
  localparam int unsigned RPROD_W    = DVD_W + RCP_W;

  localparam int unsigned TABLE_DEPTH_DEF   = 256;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MODE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MINUTE = 2'd1;

  localparam logic [DIV_W-1:0] DIV_SECOND = 12'd1;
  localparam logic [DIV_W-1:0] DIV_MINUTE = 12'd60;
  localparam logic [DIV_W-1:0] DIV_HOUR   = 12'd3600;

  // rounded-up reciprocals, exact for dividends below 2^DVD_W
  localparam int unsigned RCP_SH_MINUTE = DVD_W + 6;
  localparam int unsigned RCP_SH_HOUR   = DVD_W + 12;
  localparam logic [RCP_W-1:0] RCP_MINUTE =
    RCP_W'(((64'd1 << RCP_SH_MINUTE) + 64'(DIV_MINUTE) - 64'd1) / 64'(DIV_MINUTE));
  localparam logic [RCP_W-1:0] RCP_HOUR =
    RCP_W'(((64'd1 << RCP_SH_HOUR) + 64'(DIV_HOUR) - 64'd1) / 64'(DIV_HOUR));

  localparam logic [LEVEL_W-1:0] BURST_RESET = 32'd655360;

  // last product chunk and first quotient step
  localparam logic [CNT_W-1:0] MUL_LAST = 5'd2;
  localparam logic [CNT_W-1:0] DIV_FIRST = 5'd2;

  typedef struct packed {
    logic             accept;
    logic             load_entry;
    logic             mul_step;
    logic             acc_step;
    logic             cmp_step;
    logic             div_step;
    logic             sub_step;
    logic             add_step;
    logic             commit;
    logic [CNT_W-1:0] step;
  } klbl_cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic drain_all;
    logic div_unit;
  } klbl_sts_t;

endpackage

>>> rtl/core/klbl_req_if.sv
// klbl_req_if: request channel, valid/ready plus key, time and event count
// depends on klbl_pkg
interface klbl_req_if;
  import klbl_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key_index;
  logic [TIME_W-1:0]  now_time;
  logic [EVENT_W-1:0] event_count;

  modport source (output valid, output key_index, output now_time, output event_count,
                  input ready);
  modport sink (input valid, input key_index, input now_time, input event_count,
                output ready);
endinterface

>>> rtl/core/klbl_rsp_if.sv
// klbl_rsp_if: result channel, valid/ready plus verdict and bucket level
// depends on klbl_pkg
interface klbl_rsp_if;
  import klbl_pkg::*;

  logic               valid;
  logic               ready;
  logic               allowed;
  logic [LEVEL_W-1:0] bucket_level;

  modport source (output valid, output allowed, output bucket_level, input ready);
  modport sink (input valid, input allowed, input bucket_level, output ready);
endinterface

>>> rtl/core/klbl_ram.sv
// klbl_ram: generic single write port ram with registered read
// no dependencies
module klbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/klbl_ctrl.sv
// klbl_ctrl: sequencer for one request: table read, product chunks,
// drain compare, reciprocal quotient steps, event add and commit
// depends on klbl_pkg
module klbl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  klbl_pkg::klbl_sts_t   sts,
  output klbl_pkg::klbl_cmd_t   cmd
);
  import klbl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SUB  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.step       = cnt_r;
    cmd.accept     = (state_r == S_IDLE) && in_valid;
    cmd.load_entry = (state_r == S_READ);
    cmd.mul_step   = (state_r == S_MUL);
    cmd.acc_step   = (state_r == S_ACC);
    cmd.cmp_step   = (state_r == S_CMP);
    cmd.div_step   = (state_r == S_DIV);
    cmd.sub_step   = (state_r == S_SUB);
    cmd.add_step   = (state_r == S_ADD);
    cmd.commit     = (state_r == S_FIN) && out_free;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cnt_nxt   = '0;
        state_nxt = sts.rate_zero ? S_FIN : S_MUL;
      end
      S_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ACC: state_nxt = S_CMP;
      S_CMP: begin
        cnt_nxt = DIV_FIRST;
        if (sts.drain_all || sts.div_unit) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_SUB;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_SUB: state_nxt = S_ADD;
      S_ADD: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/klbl_dp.sv
// klbl_dp: limiter datapath: entry table and valid bits, elapsed time,
// chunked rate product, drain compare, reciprocal divider, burst check
// depends on klbl_pkg and klbl_ram
module klbl_dp #(
  parameter int unsigned TABLE_DEPTH   = klbl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned FRACTION_BITS = klbl_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  klbl_pkg::klbl_cmd_t              cmd,
  output klbl_pkg::klbl_sts_t              sts,
  input  logic [klbl_pkg::KEY_W-1:0]       key_index,
  input  logic [klbl_pkg::TIME_W-1:0]      now_time,
  input  logic [klbl_pkg::EVENT_W-1:0]     event_count,
  input  logic [klbl_pkg::LEVEL_W-1:0]     leak_rate,
  input  logic [klbl_pkg::LEVEL_W-1:0]     burst_limit,
  input  logic [klbl_pkg::MODE_W-1:0]      interval_mode,
  output logic                             allowed,
  output logic [klbl_pkg::LEVEL_W-1:0]     bucket_level
);
  import klbl_pkg::*;

  // keys are 8 bits, so no more than 256 entries can ever be reached
  localparam int unsigned ENTRIES = (TABLE_DEPTH < KEY_SPAN) ? TABLE_DEPTH : KEY_SPAN;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EV_SH_W = EVENT_W + FRACTION_BITS;
  localparam int unsigned SUM_W   = ((EV_SH_W > LEVEL_W) ? EV_SH_W : LEVEL_W) + 1;

  logic [IDX_W-1:0]   key_map [KEY_SPAN];
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;

  logic               valid_r [ENTRIES];
  logic [IDX_W-1:0]   key_r;
  logic               vld_r;
  logic [TIME_W-1:0]  now_r;
  logic [EVENT_W-1:0] events_r;
  logic [TIME_W-1:0]  elapsed_r;
  logic [LEVEL_W-1:0] level_r;
  logic [PP_W-1:0]    pp_r;
  logic [1:0]         ppk_r;
  logic [PROD_W-1:0]  acc_r;
  logic [QUO_W-1:0]   ld_r;
  logic [QUO_W-1:0]   rem_r;
  logic [LEVEL_W-1:0] quo_r;
  logic               ok_r;
  logic               allowed_r;
  logic [LEVEL_W-1:0] bucket_level_r;

  logic [TIME_W-1:0]  then_sel;
  logic [LEVEL_W-1:0] level_sel;
  logic [DIV_W-1:0]   div_sel;
  logic [RCP_W-1:0]   rcp_sel;
  logic [CHUNK_W-1:0] chunk;
  logic [PROD_W-1:0]  pp_shifted;
  logic [PROD_W-1:0]  q_full;
  logic [DVD_W-1:0]   dvd;
  logic [RPROD_W-1:0] rprod;
  logic [CHUNK_W-1:0] qpart;
  logic [SUM_W-1:0]   sum;
  logic               sum_ok;

  for (genvar k = 0; k < KEY_SPAN; k++) begin : g_key_map
    localparam int unsigned KM = k % TABLE_DEPTH;
    assign key_map[k] = KM[IDX_W-1:0];
  end

  assign raddr = key_map[key_index];

  klbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (key_r),
    .wdata ({now_r, level_r}),
    .re    (cmd.accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (interval_mode)
      MODE_SECOND: div_sel = DIV_SECOND;
      MODE_MINUTE: div_sel = DIV_MINUTE;
      default:     div_sel = DIV_HOUR;
    endcase
  end

  always_comb begin
    unique case (interval_mode)
      MODE_MINUTE: rcp_sel = RCP_MINUTE;
      default:     rcp_sel = RCP_HOUR;
    endcase
  end

  // unused entries start at time zero with level one
  assign then_sel  = vld_r ? rdata[ENTRY_W-1:LEVEL_W] : '0;
  assign level_sel = vld_r ? rdata[LEVEL_W-1:0] : (LEVEL_W'(1) << FRACTION_BITS);

  always_comb begin
    unique case (cmd.step[1:0])
      2'd0:    chunk = elapsed_r[CHUNK_W-1:0];
      2'd1:    chunk = elapsed_r[2*CHUNK_W-1:CHUNK_W];
      default: chunk = elapsed_r[3*CHUNK_W-1:2*CHUNK_W];
    endcase
  end

  always_comb begin
    unique case (ppk_r)
      2'd0:    pp_shifted = PROD_W'(pp_r);
      2'd1:    pp_shifted = PROD_W'(pp_r) << CHUNK_W;
      default: pp_shifted = PROD_W'(pp_r) << (2 * CHUNK_W);
    endcase
  end

  // quotient in two 16-bit halves: upper from the top of the dividend,
  // lower from the remainder joined with the low dividend bits
  assign dvd    = (cmd.step == '0) ? rem_r[DVD_W-1:0] : rem_r[QUO_W-1:CHUNK_W];
  assign rprod  = RPROD_W'(dvd) * RPROD_W'(rcp_sel);
  assign qpart  = (interval_mode == MODE_MINUTE) ? rprod[RCP_SH_MINUTE +: CHUNK_W]
                                                 : rprod[RCP_SH_HOUR +: CHUNK_W];

  assign q_full = acc_r >> FRACTION_BITS;
  assign sum    = SUM_W'(level_r) + (SUM_W'(events_r) << FRACTION_BITS);
  assign sum_ok = (sum <= SUM_W'(burst_limit));

  assign sts.rate_zero = (leak_rate == '0);
  assign sts.drain_all = (|q_full[PROD_W-1:QUO_W]) || (q_full[QUO_W-1:0] >= ld_r);
  assign sts.div_unit  = (interval_mode == MODE_SECOND);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r    <= raddr;
      vld_r    <= valid_r[raddr];
      now_r    <= now_time;
      events_r <= event_count;
    end
    if (cmd.load_entry) begin
      elapsed_r <= (now_r > then_sel) ? (now_r - then_sel) : '0;
      level_r   <= level_sel;
      ok_r      <= 1'b1;
    end
    if (cmd.mul_step) begin
      pp_r  <= PP_W'(chunk) * PP_W'(leak_rate);
      ppk_r <= cmd.step[1:0];
    end
    if (cmd.mul_step && (cmd.step == '0)) begin
      acc_r <= '0;
      ld_r  <= QUO_W'(level_r) * QUO_W'(div_sel);
    end else if (cmd.mul_step || cmd.acc_step) begin
      acc_r <= acc_r + pp_shifted;
    end
    if (cmd.cmp_step) begin
      rem_r <= q_full[QUO_W-1:0];
      quo_r <= '0;
      if (sts.drain_all) begin
        level_r <= '0;
      end else if (sts.div_unit) begin
        level_r <= level_r - q_full[LEVEL_W-1:0];
      end
    end
    if (cmd.div_step) begin
      if (cmd.step == DIV_FIRST) begin
        quo_r <= {qpart, {CHUNK_W{1'b0}}};
      end else if (cmd.step == '0) begin
        quo_r <= {quo_r[LEVEL_W-1:CHUNK_W], qpart};
      end else begin
        rem_r <= rem_r - QUO_W'(quo_r) * QUO_W'(div_sel);
      end
    end
    if (cmd.sub_step) begin
      level_r <= level_r - quo_r;
    end
    if (cmd.add_step) begin
      ok_r <= sum_ok;
      if (sum_ok) begin
        level_r <= sum[LEVEL_W-1:0];
      end
    end
    if (cmd.commit) begin
      allowed_r      <= ok_r;
      bucket_level_r <= level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      valid_r[key_r] <= 1'b1;
    end
  end

  assign allowed      = allowed_r;
  assign bucket_level = bucket_level_r;

endmodule

>>> rtl/core/keyed_leaky_bucket_limiter.sv
// keyed_leaky_bucket_limiter: per-key leaky-bucket limiter, one result per request
// at rate zero the drain and event add are skipped, per second or when the drain empties
// the bucket the quotient steps are; the block is ready again as the result turns valid
// the 48x32 drain product takes three 16-bit chunks, the quotient two reciprocal products
// reset clears the per-key valid bits together, no clearing pass; state and settings reset
// depends on klbl_pkg, klbl_req_if, klbl_rsp_if, klbl_ctrl, klbl_dp, klbl_ram
module keyed_leaky_bucket_limiter #(
  parameter int unsigned TABLE_DEPTH   = klbl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned FRACTION_BITS = klbl_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  klbl_req_if.sink                          in_req,
  klbl_rsp_if.source                        out_rsp,
  input  logic                              cfg_we,
  input  logic [klbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [klbl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import klbl_pkg::*;

  logic [LEVEL_W-1:0] leak_rate_r;
  logic [LEVEL_W-1:0] burst_limit_r;
  logic [MODE_W-1:0]  interval_mode_r;

  klbl_cmd_t cmd;
  klbl_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_rate_r     <= '0;
      burst_limit_r   <= BURST_RESET;
      interval_mode_r <= MODE_SECOND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEAK_RATE:     leak_rate_r     <= cfg_wdata[LEVEL_W-1:0];
        CFG_BURST_LIMIT:   burst_limit_r   <= cfg_wdata[LEVEL_W-1:0];
        CFG_INTERVAL_MODE: interval_mode_r <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  klbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  klbl_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .key_index     (in_req.key_index),
    .now_time      (in_req.now_time),
    .event_count   (in_req.event_count),
    .leak_rate     (leak_rate_r),
    .burst_limit   (burst_limit_r),
    .interval_mode (interval_mode_r),
    .allowed       (out_rsp.allowed),
    .bucket_level  (out_rsp.bucket_level)
  );

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while previous one still in work");

  // an accepted request with limiting on never leaves the bucket above burst
  a_allowed_within_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.allowed && (leak_rate_r != '0)
      |-> out_rsp.bucket_level <= burst_limit_r)
    else $error("allowed transaction exceeds burst limit");

  // refusals only happen with limiting on
  a_refuse_needs_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.allowed |-> leak_rate_r != '0)
    else $error("transaction refused with limiting disabled");

endmodule

>>> bench/keyed_leaky_bucket_limiter_test.sv
`timescale 1ns / 100ps
// keyed_leaky_bucket_limiter_test: self-checking bench for the per-key leaky-bucket limiter
// runs directed and random request traffic and checks each verdict against a local bucket model
// depends on klbl_pkg, klbl_req_if, klbl_rsp_if and the keyed_leaky_bucket_limiter rtl
module keyed_leaky_bucket_limiter_test;
  import klbl_pkg::*;

  localparam int unsigned FRAC          = FRACTION_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam logic [MODE_W-1:0]    MODE_HOUR  = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [TIME_W-1:0]    TIME_MAX   = '1;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX  = '1;

  typedef struct packed {
    logic               allowed;
    logic [LEVEL_W-1:0] level;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  klbl_req_if req_ch ();
  klbl_rsp_if rsp_ch ();

  keyed_leaky_bucket_limiter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bucket model state
  logic               slot_valid [KEY_SPAN];
  logic [TIME_W-1:0]  slot_time  [KEY_SPAN];
  logic [LEVEL_W-1:0] slot_level [KEY_SPAN];
  logic [LEVEL_W-1:0] leak_rate_q;
  logic [LEVEL_W-1:0] burst_limit_q;
  logic [MODE_W-1:0]  interval_q;

  verdict_t expected_verdicts [$];
  logic [TIME_W-1:0] time_base;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned allowed_seen;
  int unsigned refused_seen;
  int unsigned settings_count;
  int unsigned cycle_count;
  int unsigned hold_cycles;
  bit tx_idle_en;
  bit rx_idle_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [LEVEL_W-1:0] whole_units(input int unsigned whole);
    return LEVEL_W'(whole) << FRAC;
  endfunction

  function automatic void clear_bucket_table();
    for (int i = 0; i < KEY_SPAN; i++) begin
      slot_valid[i] = 1'b0;
      slot_time[i]  = '0;
      slot_level[i] = '0;
    end
    leak_rate_q   = '0;
    burst_limit_q = BURST_RESET;
    interval_q    = MODE_SECOND;
  endfunction

  function automatic verdict_t compute_bucket_verdict(input logic [KEY_W-1:0] key,
                                                      input logic [TIME_W-1:0] stamp,
                                                      input logic [EVENT_W-1:0] events);
    logic [TIME_W-1:0]  then_t;
    logic [TIME_W-1:0]  elapsed;
    logic [79:0]        product;
    logic [63:0]        drain;
    logic [63:0]        divisor;
    logic [33:0]        level;
    logic [33:0]        sum;
    verdict_t           result;
    if (slot_valid[key]) begin
      then_t = slot_time[key];
      level  = {2'b00, slot_level[key]};
    end else begin
      then_t = '0;
      level  = {2'b00, whole_units(1)};
    end
    result.allowed = 1'b1;
    if (leak_rate_q != '0) begin
      elapsed = (stamp > then_t) ? stamp - then_t : '0;
      case (interval_q)
        MODE_SECOND: divisor = {52'd0, DIV_SECOND};
        MODE_MINUTE: divisor = {52'd0, DIV_MINUTE};
        default:     divisor = {52'd0, DIV_HOUR};
      endcase
      product = {32'd0, elapsed} * {48'd0, leak_rate_q};
      drain   = product[79:16] / divisor;
      if (drain >= {30'd0, level}) level = '0;
      else level = level - drain[33:0];
      sum = level + ({18'd0, events} << FRAC);
      if (sum > {2'b00, burst_limit_q}) result.allowed = 1'b0;
      else level = sum;
    end
    slot_valid[key] = 1'b1;
    slot_time[key]  = stamp;
    slot_level[key] = level[LEVEL_W-1:0];
    result.level    = level[LEVEL_W-1:0];
    return result;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    case (index)
      CFG_LEAK_RATE:     leak_rate_q   = data;
      CFG_BURST_LIMIT:   burst_limit_q = data;
      CFG_INTERVAL_MODE: interval_q    = data[MODE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    int unsigned waited;
    req_ch.valid <= 1'b0;
    waited = 0;
    while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [LEVEL_W-1:0] rate, input logic [LEVEL_W-1:0] burst,
                               input logic [MODE_W-1:0] mode);
    drain_results();
    write_reg(CFG_LEAK_RATE, rate);
    write_reg(CFG_BURST_LIMIT, burst);
    write_reg(CFG_INTERVAL_MODE, CFG_DATA_W'(mode));
    settings_count++;
  endtask

  task automatic offer_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp,
                               input logic [EVENT_W-1:0] events);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.key_index   <= key;
    req_ch.now_time    <= stamp;
    req_ch.event_count <= events;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_verdicts.push_back(compute_bucket_verdict(key, stamp, events));
    requests_sent++;
  endtask

  // hot keys with advancing time, plus late timestamps and fully random noise
  task automatic run_mixed_traffic(input int unsigned count, input int unsigned step);
    logic [KEY_W-1:0]   hot_keys [8];
    logic [TIME_W-1:0]  stamp;
    logic [EVENT_W-1:0] events;
    int unsigned pick;
    for (int i = 0; i < 8; i++) hot_keys[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      pick   = $urandom_range(0, 15);
      events = ($urandom_range(0, 15) == 0) ? EVENT_W'($urandom) : EVENT_W'($urandom_range(0, 3));
      if (pick == 0) begin
        offer_request(KEY_W'($urandom), TIME_W'({$urandom, $urandom}), EVENT_W'($urandom));
      end else if (pick == 1) begin
        stamp = time_base - TIME_W'($urandom_range(0, 1 << 20));
        offer_request(hot_keys[$urandom_range(0, 7)], stamp, events);
      end else begin
        time_base = time_base + TIME_W'($urandom_range(0, step));
        offer_request(hot_keys[$urandom_range(0, 7)], time_base, events);
      end
    end
  endtask

  task automatic test_rate_zero_defaults();
    offer_request(8'd0, '0, 16'd0);
    offer_request(8'd255, TIME_MAX, 16'hFFFF);
    offer_request(8'd0, 48'd5, 16'd100);
  endtask

  task automatic test_fill_drain_refuse();
    apply_setting(whole_units(1), whole_units(10), MODE_SECOND);
    offer_request(8'd1, 48'd0, 16'd9);
    offer_request(8'd1, 48'd0, 16'd1);
    offer_request(8'd1, 48'd2 << FRAC, 16'd0);
    // late timestamp, no drain
    offer_request(8'd1, 48'd1 << FRAC, 16'd2);
    offer_request(8'd1, 48'd102 << FRAC, 16'd1);
    offer_request(8'd2, 48'h0000_1234_5678, 16'd10);
  endtask

  task automatic test_extreme_registers();
    apply_setting(LEVEL_MAX, LEVEL_MAX, MODE_SECOND);
    offer_request(8'd3, TIME_MAX, 16'hFFFF);
    offer_request(8'd3, TIME_MAX, 16'hFFFF);
    offer_request(8'd3, TIME_MAX, 16'd0);
    apply_setting(whole_units(1), '0, MODE_SECOND);
    offer_request(8'd4, 48'd0, 16'd0);
    offer_request(8'd4, 48'd1 << FRAC, 16'd0);
  endtask

  task automatic test_interval_units();
    apply_setting(whole_units(60), whole_units(10), MODE_MINUTE);
    offer_request(8'd5, 48'd30 << FRAC, 16'd0);
    apply_setting(whole_units(60), whole_units(10), MODE_HOUR);
    offer_request(8'd6, 48'd30 << FRAC, 16'd0);
    // spare mode code behaves as hours
    apply_setting(whole_units(60), whole_units(10), MODE_SPARE);
    offer_request(8'd7, 48'd30 << FRAC, 16'd0);
    // unused register index must leave the settings alone
    drain_results();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    offer_request(8'd8, 48'd0, 16'd9);
  endtask

  task automatic test_setting_sweep();
    apply_setting(whole_units(1), whole_units(10), MODE_SECOND);
    run_mixed_traffic(190, 1 << 16);
    apply_setting(32'h0000_4000, whole_units(4), MODE_SECOND);
    run_mixed_traffic(190, 1 << 17);
    apply_setting(whole_units(30), whole_units(5), MODE_MINUTE);
    run_mixed_traffic(190, 1 << 17);
    apply_setting(whole_units(600), whole_units(3), MODE_HOUR);
    run_mixed_traffic(190, 6 << 16);
    apply_setting('0, '0, MODE_SPARE);
    run_mixed_traffic(190, 1 << 16);
    time_base = {1'b1, 47'($urandom)};
    apply_setting(LEVEL_MAX, LEVEL_MAX, MODE_SECOND);
    run_mixed_traffic(190, 1 << 20);
    apply_setting(32'd1, '0, MODE_MINUTE);
    run_mixed_traffic(190, 1 << 16);
    apply_setting(LEVEL_W'($urandom_range(1, 1 << 20)), LEVEL_W'($urandom_range(0, 32 << 16)),
                  MODE_W'($urandom_range(0, 3)));
    run_mixed_traffic(190, 1 << 16);
    apply_setting(LEVEL_W'($urandom), LEVEL_W'($urandom), MODE_W'($urandom_range(0, 3)));
    run_mixed_traffic(190, $urandom_range(1, 1 << 24));
  endtask

  task automatic test_output_backpressure();
    apply_setting(whole_units(1), whole_units(10), MODE_SECOND);
    tx_idle_en  = 1'b0;
    hold_cycles = 300;
    run_mixed_traffic(40, 1 << 16);
    tx_idle_en  = 1'b1;
  endtask

  task automatic test_full_rate_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    apply_setting(whole_units(2), whole_units(8), MODE_SECOND);
    run_mixed_traffic(150, 1 << 16);
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual allowed %0d level 0x%08h",
                 $time, rsp_ch.allowed, rsp_ch.bucket_level);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (rsp_ch.allowed !== want.allowed) begin
          $display("%0t ns: allowed mismatch, expected %0d actual %0d",
                   $time, want.allowed, rsp_ch.allowed);
          error_count++;
        end
        if (rsp_ch.bucket_level !== want.level) begin
          $display("%0t ns: bucket_level mismatch, expected 0x%08h actual 0x%08h",
                   $time, want.level, rsp_ch.bucket_level);
          error_count++;
        end
        if (want.allowed) allowed_seen++;
        else refused_seen++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_verdicts.size());
    $display("keyed_leaky_bucket_limiter_test: FAIL");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_LEAK_RATE;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.key_index   <= '0;
    req_ch.now_time    <= '0;
    req_ch.event_count <= '0;
    error_count    = 0;
    requests_sent  = 0;
    allowed_seen   = 0;
    refused_seen   = 0;
    settings_count = 1;
    hold_cycles    = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    time_base      = 48'h0000_0100_0000;
    clear_bucket_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rate_zero_defaults();
    test_fill_drain_refuse();
    test_extreme_registers();
    test_interval_units();
    test_setting_sweep();
    test_output_backpressure();
    test_full_rate_stream();

    drain_results();
    if (expected_verdicts.size() != 0) begin
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, expected_verdicts.size());
      error_count += expected_verdicts.size();
    end
    $display("%0d requests over %0d register settings: %0d allowed, %0d refused",
             requests_sent, settings_count, allowed_seen, refused_seen);
    $display("traffic mixed hot keys, late and random timestamps, stalls and a long hold-off");
    if (error_count == 0) begin
      $display("keyed_leaky_bucket_limiter_test: PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("keyed_leaky_bucket_limiter_test: FAIL");
    end
    $finish;
  end

endmodule
